[rtl/bpa_pkg.sv]
package bpa_pkg;

  localparam int unsigned NumPagesDefault = 4096;
  localparam int unsigned PageBits        = 12;
  localparam int unsigned WordBits        = 64;
  localparam int unsigned AddrW           = 40;
  localparam int unsigned CountW          = 13;
  localparam int unsigned BaseW           = 24;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESERVE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_ENABLED = 1'd0,
    REG_TOTAL   = 1'd1
  } reg_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FIX,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;    // latch item, set up pointers
    logic scan;     // one page of first-fit scan
    logic mark;     // one page of marking / clearing
    logic fix;      // allocate found: rewind to run start
    logic finish;   // load result register
    logic init;     // one page of the after-reset fill
  } bpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic guard_fail;
    logic is_alloc;
    logic scan_last;
    logic run_found;
    logic mark_last;
    logic init_last;
  } bpa_sts_t;

endpackage

[rtl/bpa_ctrl.sv]
module bpa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_free_i,
  input  bpa_pkg::bpa_sts_t sts_i,
  output bpa_pkg::bpa_cmd_t cmd_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: if (sts_i.init_last) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_OUT;
          if (!sts_i.guard_fail) state_d = sts_i.is_alloc ? S_SCAN : S_MARK;
        end
      end
      S_SCAN: begin
        if (sts_i.run_found) state_d = S_FIX;
        else if (sts_i.scan_last) state_d = S_OUT;
      end
      S_FIX:  state_d = S_MARK;
      S_MARK: if (sts_i.mark_last) state_d = S_OUT;
      S_OUT:  if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: cmd_o.init = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_SCAN: cmd_o.scan = !sts_i.run_found;
      S_FIX:  cmd_o.fix = 1'b1;
      S_MARK: cmd_o.mark = 1'b1;
      S_OUT:  cmd_o.finish = out_free_i;
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/bpa_datapath.sv]
module bpa_datapath #(
  parameter int unsigned NumPages = bpa_pkg::NumPagesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bpa_pkg::bpa_cmd_t          cmd_i,
  input  logic                       enabled_i,
  input  logic [bpa_pkg::CountW-1:0] total_i,
  input  logic [1:0]                 kind_i,
  input  logic [bpa_pkg::AddrW-1:0]  address_i,
  input  logic [bpa_pkg::CountW-1:0] page_count_i,
  input  logic [bpa_pkg::AddrW-1:0]  byte_length_i,
  output bpa_pkg::bpa_sts_t          sts_o,
  output logic [1:0]                 status_o,
  output logic [bpa_pkg::BaseW-1:0]  base_o,
  output logic [bpa_pkg::CountW-1:0] free_o
);
  import bpa_pkg::*;

  localparam int unsigned PW = $clog2(NumPages) + 1;
  localparam int unsigned IW = $clog2(NumPages);
  localparam int unsigned LW = AddrW + 2;

  // one bit per page, set = used; filled with ones by a pass after reset
  logic                map_mem [NumPages];
  logic                rd_q;
  logic [IW-1:0]       init_q;
  logic [CountW-1:0]   free_q;

  logic [PW-1:0]     limit, ptr_q, ptr_d, end_q;
  logic [CountW-1:0] run_q, cnt_q;
  logic              clr_q, alloc_q, ok_q;
  logic [BaseW-1:0]  base_q;
  logic [PW-1:0]     start_p, first_p;
  logic [LW-1:0]     end_bytes;
  logic [LW-PageBits-1:0] end_pg;
  logic [PW-1:0]     end_c;
  logic              guard_fail;
  logic              page_used;
  logic              run_hit;
  logic              mark_we;

  assign limit = (LW'(total_i) < LW'(NumPages)) ? PW'(total_i) : PW'(NumPages);
  assign end_bytes = LW'(address_i) + LW'(byte_length_i) + LW'((1 << PageBits) - 1);
  assign end_pg = end_bytes[LW-1:PageBits];
  assign end_c = ((LW-PageBits)'(limit) < end_pg) ? limit : PW'(end_pg);

  always_comb begin
    guard_fail = 1'b1;
    start_p = '0;
    if (enabled_i) begin
      case (kind_i)
        KIND_ALLOC: guard_fail = (page_count_i == '0);
        KIND_RELEASE: begin
          guard_fail = (address_i == '0) || (page_count_i == '0) ||
            ((LW)'(address_i[AddrW-1:PageBits]) + LW'(page_count_i) > LW'(limit));
        end
        KIND_RESERVE:
          guard_fail = ((AddrW-PageBits)'(limit) <= address_i[AddrW-1:PageBits]);
        default: guard_fail = 1'b1;
      endcase
    end
    start_p = PW'(address_i[AddrW-1:PageBits]);
  end

  // rd_q always holds the bit of the page at ptr_q
  assign page_used = rd_q;
  assign first_p   = ptr_q + PW'(1) - PW'(cnt_q);
  assign run_hit   = !page_used && (run_q + CountW'(1) == cnt_q);
  assign mark_we   = cmd_i.mark && (ptr_q < end_q);

  assign sts_o.guard_fail = guard_fail;
  assign sts_o.is_alloc   = (kind_i == KIND_ALLOC);
  assign sts_o.scan_last  = (ptr_q >= limit);
  assign sts_o.run_found  = (run_q == cnt_q) && (cnt_q != '0);
  assign sts_o.mark_last  = (ptr_q + 1'b1 >= end_q) || (ptr_q >= end_q);
  assign sts_o.init_last  = (init_q == IW'(NumPages - 1));

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.start) begin
      ptr_d = (kind_i == KIND_ALLOC) ? '0 : start_p;
    end else if (cmd_i.scan) begin
      if (ptr_q < limit && !run_hit) ptr_d = ptr_q + PW'(1);
    end else if (cmd_i.fix) begin
      ptr_d = first_p;
    end else if (cmd_i.mark) begin
      ptr_d = ptr_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      free_q <= '0;
    end else begin
      if (cmd_i.init) init_q <= init_q + IW'(1);
      if (mark_we) begin
        if (clr_q && page_used) free_q <= free_q + CountW'(1);
        if (!clr_q && !page_used) free_q <= free_q - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) map_mem[init_q] <= 1'b1;
    else if (mark_we) map_mem[ptr_q[IW-1:0]] <= !clr_q;
    rd_q <= map_mem[ptr_d[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.start) begin
      cnt_q   <= page_count_i;
      run_q   <= '0;
      alloc_q <= (kind_i == KIND_ALLOC);
      clr_q   <= (kind_i == KIND_RELEASE);
      ok_q    <= !guard_fail;
      base_q  <= '0;
      if (kind_i == KIND_ALLOC) begin
        end_q <= '0;
      end else if (kind_i == KIND_RELEASE) begin
        end_q <= start_p + PW'(page_count_i);
      end else begin
        end_q <= end_c;
      end
    end else if (cmd_i.scan) begin
      if (ptr_q < limit) run_q <= page_used ? '0 : run_q + CountW'(1);
    end else if (cmd_i.fix) begin
      end_q  <= ptr_q + PW'(1);
      base_q <= BaseW'({first_p, {PageBits{1'b0}}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      free_o <= free_q;
      base_o <= base_q;
      if (!ok_q) status_o <= ST_IGNORED;
      else if (alloc_q && base_q == '0 && !(end_q != '0)) status_o <= ST_NOSPACE;
      else status_o <= ST_DONE;
    end
  end

endmodule

[rtl/bitmap_page_allocator_core.sv]
// a guarded item goes straight to the result beat; release and reserve walk their range
// one page per cycle; allocate scans first-fit for a free run, then rewinds to it and marks it
// throughput: one item at a time, next beat taken the cycle after the result loads
// reset: async active low; a fill pass marks every page used, input held off
// meanwhile; free count 0, disabled, total 4096
module bitmap_page_allocator_core #(
  parameter int unsigned NumPages = bpa_pkg::NumPagesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // address[39:0], page_count[52:40], byte_length[92:53]
  input  logic [1:0]   s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // base_address[23:0], free_pages[36:24]
  output logic [1:0]   m_axis_tuser,  // status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [12:0]  cfg_data_i
);
  import bpa_pkg::*;

  logic enabled_q;
  logic [CountW-1:0] total_q;
  logic out_v_q;
  bpa_cmd_t cmd;
  bpa_sts_t sts;
  logic [1:0] status;
  logic [BaseW-1:0] base;
  logic [CountW-1:0] freep;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      total_q   <= CountW'(4096);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_ENABLED) enabled_q <= cfg_data_i[0];
      else total_q <= cfg_data_i;
    end
  end

  bpa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (!out_v_q || m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpa_datapath #(.NumPages(NumPages)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .enabled_i     (enabled_q),
    .total_i       (total_q),
    .kind_i        (s_axis_tready ? s_axis_tuser : 2'(KIND_NONE)),
    .address_i     (s_axis_tdata[39:0]),
    .page_count_i  (s_axis_tdata[52:40]),
    .byte_length_i (s_axis_tdata[92:53]),
    .sts_o         (sts),
    .status_o      (status),
    .base_o        (base),
    .free_o        (freep)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (cmd.finish) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b0, freep, base};
  assign m_axis_tuser  = status;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept while busy");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_v_q || m_axis_tready)) else $error("result overwritten");
`endif

endmodule
